FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the variance presence detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/wvpd_pkg.sv
// Package with the fixed field widths and constants of the variance presence detector.
`default_nettype none

package wvpd_pkg;

  // Field widths.
  localparam int SAMPLE_W = 8;
  localparam int THRESH_W = 16;
  localparam int VAR_W    = 17;
  // Width of the square of one sample; its largest value is 128 squared.
  localparam int SQR_W    = 15;

  // Saturated variance and threshold after reset.
  localparam logic [VAR_W-1:0]    VAR_SAT      = 17'h10000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd128;

endpackage

`default_nettype wire

FILE: rtl/wvpd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module wvpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  wire logic                                 clk,
  input  wire logic                                 wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic                                 rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is requested.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: rtl/windowed_variance_presence_detector_top.sv
// Top level of the windowed variance presence detector.
//
// Usage: one signed dBm sample enters per input transaction (in_valid, in_stall);
// every sample gives one result transaction (out_valid, out_stall). A transaction
// completes at a rising edge where valid is high and stall is low.
// The last WINDOW samples live in a ring RAM; running sums are updated per sample.
// Until WINDOW samples have arrived, results carry window_full = 0 and zero fields.
// Each sample passes six registers before its result is valid (input register, sum
// update, products, variance compare, reciprocal multiply, quotient fix-up).
// Throughput: one sample per cycle while the receiver does not stall; the running
// sums close their loop through a single register.
// When the receiver stalls, bubbles in the six stages are filled first; in_stall
// rises only once every stage holds a transaction, and the result holds steady.
// cfg_wr_en writes the threshold (sixteenths); do so only while the block is idle.
// Reset clears the sums, fill state, presence flag and threshold (128). The ring
// RAM needs no clearing pass: entries are masked until the ring has filled once.
`default_nettype none

`include "assert_macros.svh"

module windowed_variance_presence_detector_top
  import wvpd_pkg::*;
#(
  parameter int WINDOW = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration port.
  input  wire logic                       cfg_wr_en,
  input  wire logic [THRESH_W-1:0]        cfg_wr_data,
  // Input channel.
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_dbm,
  // Result channel.
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_window_full,
  output logic [VAR_W-1:0]                out_variance_q4,
  output logic                            out_present,
  output logic                            out_status_changed
);

  // Derived sizes.
  localparam int N2       = WINDOW * WINDOW;
  localparam int ADDR_W   = $clog2(WINDOW);
  localparam int SUM_W    = $clog2(128 * WINDOW) + 1;
  localparam int SQ_W     = $clog2(16384 * WINDOW + 1);
  localparam int PROD_W   = $clog2(16384 * N2 + 1);
  localparam int DEV16_W  = PROD_W + 4;
  localparam int LIM_W    = $clog2(65535 * N2 + 1);
  localparam int CMP_W    = (DEV16_W > LIM_W) ? DEV16_W : LIM_W;
  localparam int RECIP_SH = DEV16_W;
  localparam int RECIP_W  = RECIP_SH - $clog2(N2) + 1;
  localparam int RPROD_W  = DEV16_W + RECIP_W;
  localparam int N2_W     = $clog2(N2 + 1);
  localparam int QP_W     = VAR_W + N2_W;
  localparam int REM_W    = ((DEV16_W > QP_W) ? DEV16_W : QP_W) + 1;

  localparam longint RECIP = (longint'(1) << RECIP_SH) / N2;
  localparam logic [DEV16_W-1:0] SAT_LIM   = DEV16_W'(65536 * N2);
  localparam logic [LIM_W-1:0]   LIM_RESET = LIM_W'(int'(THRESH_RESET) * N2);
  localparam logic [ADDR_W-1:0]  LAST_SLOT = ADDR_W'(WINDOW - 1);

  // Pipeline occupancy and movement.
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r, out_valid_r;
  logic a_mv, b_mv, c_mv, d_mv, e_mv;
  logic a_free, b_free, c_free, d_free, e_free, o_free;
  logic in_acc;

  // Architectural state.
  logic [LIM_W-1:0]        limit_r;
  logic [ADDR_W-1:0]       slot_r;
  logic                    filled_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    present_r;

  // Stage payloads.
  logic signed [SAMPLE_W-1:0] a_sample_r;
  logic [ADDR_W-1:0]          a_slot_r;
  logic                       a_oldv_r;
  logic                       a_full_r;
  logic                       b_full_r;
  logic [PROD_W-1:0]          c_nsq_r, c_s2_r;
  logic                       c_full_r;
  logic [DEV16_W-1:0]         d_dev16_r;
  logic                       d_sat_r, d_det_r, d_chg_r, d_full_r;
  logic [DEV16_W-1:0]         e_dev16_r;
  logic [VAR_W-1:0]           e_qest_r;
  logic                       e_sat_r, e_det_r, e_chg_r, e_full_r;
  logic                       o_full_r, o_present_r, o_chg_r;
  logic [VAR_W-1:0]           o_var_r;

  logic [SAMPLE_W-1:0] ram_rdata;

  // Handshake chain: a stage takes a transaction when it is empty or is emptying.
  always_comb begin
    o_free   = !out_valid_r || !out_stall;
    e_mv     = v_e_r && o_free;
    e_free   = !v_e_r || e_mv;
    d_mv     = v_d_r && e_free;
    d_free   = !v_d_r || d_mv;
    c_mv     = v_c_r && d_free;
    c_free   = !v_c_r || c_mv;
    b_mv     = v_b_r && c_free;
    b_free   = !v_b_r || b_mv;
    a_mv     = v_a_r && b_free;
    a_free   = !v_a_r || a_mv;
    in_acc   = in_valid && a_free;
    in_stall = !a_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      v_c_r       <= 1'b0;
      v_d_r       <= 1'b0;
      v_e_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) v_a_r <= in_acc;
      if (b_free) v_b_r <= a_mv;
      if (c_free) v_c_r <= b_mv;
      if (d_free) v_d_r <= c_mv;
      if (e_free) v_e_r <= d_mv;
      if (o_free) out_valid_r <= e_mv;
    end
  end

  // Threshold register, held pre-scaled by the window size squared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIM_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= LIM_W'(LIM_W'(cfg_wr_data) * LIM_W'(N2));
    end
  end

  // Ring write slot and fill tracking; the old entry is read as the sample is taken.
  logic [ADDR_W-1:0] slot_nxt;
  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      filled_r <= 1'b0;
    end else if (in_acc) begin
      slot_r <= slot_nxt;
      if (slot_r == LAST_SLOT) filled_r <= 1'b1;
    end
  end

  // Stage A: input register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_sample_r <= in_sample_dbm;
      a_slot_r   <= slot_r;
      a_oldv_r   <= filled_r;
      a_full_r   <= filled_r || (slot_r == LAST_SLOT);
    end
  end

  wvpd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (a_mv),
    .wr_addr (a_slot_r),
    .wr_data (a_sample_r),
    .rd_en   (in_acc),
    .rd_addr (slot_r),
    .rd_data (ram_rdata)
  );

  // Stage B: running sums; the sample leaving the window counts as zero before the
  // ring has filled once.
  logic signed [SAMPLE_W-1:0] old_s;
  logic signed [15:0]         x_sq, o_sq;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [SQ_W-1:0]            sq_nxt;

  always_comb begin
    old_s   = a_oldv_r ? ram_rdata : '0;
    x_sq    = 16'(a_sample_r) * 16'(a_sample_r);
    o_sq    = 16'(old_s) * 16'(old_s);
    sum_nxt = sum_r + SUM_W'(a_sample_r) - SUM_W'(old_s);
    sq_nxt  = sq_r + SQ_W'(x_sq[SQR_W-1:0]) - SQ_W'(o_sq[SQR_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
    end else if (a_mv) begin
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_mv) b_full_r <= a_full_r;
  end

  // Stage C: N times the sum of squares, and the square of the sum.
  logic signed [2*SUM_W-1:0] s2_full;
  logic [PROD_W-1:0]         c_nsq_nxt;

  always_comb begin
    s2_full   = (2*SUM_W)'(sum_r) * (2*SUM_W)'(sum_r);
    c_nsq_nxt = PROD_W'(sq_r) * PROD_W'(WINDOW);
  end

  always_ff @(posedge clk) begin
    if (b_mv) begin
      c_nsq_r  <= c_nsq_nxt;
      c_s2_r   <= s2_full[PROD_W-1:0];
      c_full_r <= b_full_r;
    end
  end

  // Stage D: scaled deviation, presence decision and saturation check.
  logic [PROD_W-1:0]  dev;
  logic [DEV16_W-1:0] dev16;
  logic               det, sat;

  always_comb begin
    dev   = c_nsq_r - c_s2_r;
    dev16 = c_full_r ? {dev, 4'b0000} : '0;
    det   = CMP_W'(dev16) > CMP_W'(limit_r);
    sat   = dev16 >= SAT_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
    end else if (c_mv && c_full_r) begin
      present_r <= det;
    end
  end

  always_ff @(posedge clk) begin
    if (c_mv) begin
      d_dev16_r <= dev16;
      d_sat_r   <= sat;
      d_det_r   <= det;
      d_chg_r   <= c_full_r && (det != present_r);
      d_full_r  <= c_full_r;
    end
  end

  // Stage E: quotient estimate by the reciprocal of N squared; it is at most one low.
  logic [RPROD_W-1:0] recip_prod;
  assign recip_prod = RPROD_W'(d_dev16_r) * RPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (d_mv) begin
      e_dev16_r <= d_dev16_r;
      e_qest_r  <= recip_prod[RECIP_SH +: VAR_W];
      e_sat_r   <= d_sat_r;
      e_det_r   <= d_det_r;
      e_chg_r   <= d_chg_r;
      e_full_r  <= d_full_r;
    end
  end

  // Output stage: fix up the quotient from the remainder, then saturate.
  logic [QP_W-1:0]  qprod;
  logic [REM_W-1:0] rem;
  logic [VAR_W-1:0] q_fix;

  always_comb begin
    qprod = QP_W'(e_qest_r) * QP_W'(N2);
    rem   = REM_W'(e_dev16_r) - REM_W'(qprod);
    q_fix = e_qest_r + VAR_W'(rem >= REM_W'(N2));
  end

  always_ff @(posedge clk) begin
    if (e_mv) begin
      o_full_r    <= e_full_r;
      o_var_r     <= e_sat_r ? VAR_SAT : q_fix;
      o_present_r <= e_det_r;
      o_chg_r     <= e_chg_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_window_full    = o_full_r;
  assign out_variance_q4    = o_var_r;
  assign out_present        = o_present_r;
  assign out_status_changed = o_chg_r;

  // Checks on the pipeline and fill logic.
  `ASSERT_IMPLIES(a_stall_only_when_held, clk, rst_n, in_stall, v_a_r && !b_free)
  `ASSERT_NEXT(a_filled_sticks, clk, rst_n, filled_r, filled_r)
  `ASSERT_IMPLIES(a_old_entry_needs_full, clk, rst_n, v_a_r && a_oldv_r, a_full_r)
  `ASSERT_IMPLIES(a_partial_window_zero, clk, rst_n, out_valid && !out_window_full,
                  out_variance_q4 == '0 && !out_present && !out_status_changed)

endmodule

`default_nettype wire

FILE: verif/windowed_variance_presence_detector_top_tb.sv
// Self-checking testbench for the windowed variance presence detector.
`timescale 1ns / 1ps

module windowed_variance_presence_detector_top_tb;
  import wvpd_pkg::*;

  localparam int WINDOW      = 20;
  localparam int LATENCY     = 6;
  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 80;
  localparam int MAX_REPORTS = 10;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 240;

  // One result transaction, field for field.
  typedef struct packed {
    logic             window_full;
    logic [VAR_W-1:0] variance_q4;
    logic             present;
    logic             status_changed;
  } detection_t;

  // Shapes of the random sample stream.
  typedef enum logic [2:0] {
    MODE_STEADY,
    MODE_LOW,
    MODE_MODERATE,
    MODE_HIGH,
    MODE_WIDE_NEG,
    MODE_FULL,
    MODE_EXTREME
  } sample_mode_e;

  // Keeps its own copy of the window and predicts each detection in order.
  class detection_scoreboard;
    logic signed [SAMPLE_W-1:0] ring [WINDOW];
    int unsigned                slot;
    bit                         filled;
    longint                     running_total;
    longint                     square_sum;
    bit                         present_flag;
    logic [THRESH_W-1:0]        threshold;
    detection_t                 pending_q [$];
    int unsigned                mismatches;
    int unsigned                results_seen;
    int unsigned                samples_seen;
    int unsigned                presence_flips;
    int unsigned                saturations;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot           = 0;
      filled         = 1'b0;
      running_total  = 0;
      square_sum     = 0;
      present_flag   = 1'b0;
      threshold      = THRESH_RESET;
      mismatches     = 0;
      results_seen   = 0;
      samples_seen   = 0;
      presence_flips = 0;
      saturations    = 0;
    endfunction

    function void set_threshold(input logic [THRESH_W-1:0] value);
      threshold = value;
    endfunction

    // Advances the window by one accepted sample and queues the detection it causes.
    function void note_sample(input logic signed [SAMPLE_W-1:0] sample);
      longint     x;
      longint     old;
      longint     spread;
      longint     scaled;
      longint     quotient;
      detection_t d;
      x   = sample;
      old = ring[slot];
      running_total += x - old;
      square_sum    += x * x - old * old;
      ring[slot] = sample;
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      if (slot == 0) filled = 1'b1;
      d = '0;
      // Until the ring has wrapped once the result carries only zeros.
      if (filled) begin
        spread = WINDOW * square_sum - running_total * running_total;
        if (spread < 0) spread = 0;
        scaled   = 16 * spread;
        quotient = scaled / (WINDOW * WINDOW);
        d.window_full = 1'b1;
        if (quotient >= longint'(VAR_SAT)) begin
          d.variance_q4 = VAR_SAT;
          saturations++;
        end else begin
          d.variance_q4 = quotient[VAR_W-1:0];
        end
        // The decision uses the exact spread, never the saturated variance.
        d.present        = scaled > longint'(threshold) * WINDOW * WINDOW;
        d.status_changed = d.present != present_flag;
        if (d.status_changed) presence_flips++;
        present_flag = d.present;
      end
      samples_seen++;
      pending_q.push_back(d);
    endfunction

    // Compares one accepted result with the oldest expected detection.
    function void check_result(input detection_t got);
      detection_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d arrived with nothing expected", $time, results_seen);
        return;
      end
      want = pending_q.pop_front();
      if (got.window_full !== want.window_full || got.variance_q4 !== want.variance_q4 ||
          got.present !== want.present || got.status_changed !== want.status_changed) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: result %0d expected full=%0b var=%0d present=%0b changed=%0b",
                   $time, results_seen, want.window_full, want.variance_q4, want.present,
                   want.status_changed);
          $display("%0t: result %0d actual   full=%0b var=%0d present=%0b changed=%0b",
                   $time, results_seen, got.window_full, got.variance_q4, got.present,
                   got.status_changed);
        end
      end
    endfunction
  endclass

  logic                       clk           = 1'b0;
  logic                       rst_n         = 1'b0;
  logic                       cfg_wr_en     = 1'b0;
  logic [THRESH_W-1:0]        cfg_wr_data   = '0;
  logic                       in_valid      = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_dbm = '0;
  logic                       out_valid;
  logic                       out_stall     = 1'b0;
  logic                       out_window_full;
  logic [VAR_W-1:0]           out_variance_q4;
  logic                       out_present;
  logic                       out_status_changed;

  int unsigned hold_requests   = 0;
  int unsigned thresholds_used = 0;

  detection_scoreboard sb = new();

  windowed_variance_presence_detector_top #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_dbm     (in_sample_dbm),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_window_full   (out_window_full),
    .out_variance_q4   (out_variance_q4),
    .out_present       (out_present),
    .out_status_changed(out_status_changed)
  );

  // 10 ns clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_sample(in_sample_dbm);
      if (out_valid && !out_stall)
        sb.check_result({out_window_full, out_variance_q4, out_present, out_status_changed});
    end
  end

  // Ends the run if no transaction completes on either channel for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver stalls on patterns of changing density and serves long hold-off requests.
  initial begin : receiver
    int unsigned holds_done;
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned stall_pct;
    holds_done   = 0;
    hold_left    = 0;
    pattern_left = 0;
    stall_pct    = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(32, 256);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      pattern_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offers one sample and returns once the transaction has completed.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_sample_dbm <= sample;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drops valid for the given number of cycles (at least one).
  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    pause_sender(1);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // The threshold is only written once the pipeline has drained.
  task automatic write_threshold(input logic [THRESH_W-1:0] value);
    wait_for_results();
    repeat (2 * LATENCY) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_threshold(value);
    thresholds_used++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input sample_mode_e mode,
                                                             input int base);
    int value;
    case (mode)
      MODE_STEADY:   value = base + int'($urandom_range(0, 2)) - 1;
      MODE_LOW:      value = base + int'($urandom_range(0, 6)) - 3;
      MODE_MODERATE: value = base + int'($urandom_range(0, 12)) - 6;
      MODE_HIGH:     value = base + int'($urandom_range(0, 30)) - 15;
      MODE_WIDE_NEG: value = -int'($urandom_range(0, 128));
      MODE_FULL:     value = int'($urandom_range(0, 255)) - 128;
      default: begin
        case ($urandom_range(0, 3))
          0: value = -128;
          1: value = 127;
          2: value = 0;
          default: value = -1;
        endcase
      end
    endcase
    if (value > 127) value = 127;
    if (value < -128) value = -128;
    return value[SAMPLE_W-1:0];
  endfunction

  // Directed opening with the reset threshold.
  task automatic run_directed();
    int i;
    // Alternating floor and ceiling of the negative range: the window is not full for the
    // first samples, then the variance sits exactly at full scale.
    for (i = 0; i < WINDOW; i++) send_sample((i % 2 != 0) ? 8'sd0 : -8'sd128);
    // Positive samples push the variance beyond full scale, so it saturates.
    send_sample(8'sd127);
    send_sample(-8'sd128);
    send_sample(8'sd127);
    send_sample(-8'sd1);
    send_sample(8'sd1);
  endtask

  // Random segments of sample shapes, sent in bursts separated by gaps.
  task automatic run_random_phase(input int unsigned items, input bit with_hold,
                                  input bit with_drain);
    sample_mode_e mode;
    int           base;
    int unsigned  segment_left;
    int unsigned  burst_left;
    int unsigned  sent;
    mode         = MODE_STEADY;
    base         = -60;
    segment_left = 0;
    burst_left   = 0;
    for (sent = 0; sent < items; sent++) begin
      if (segment_left == 0) begin
        segment_left = $urandom_range(10, 60);
        mode = sample_mode_e'($urandom_range(0, 6));
        base = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 110))
                                           : -int'($urandom_range(20, 100));
      end
      segment_left--;
      // The receiver holds off while the sender keeps offering back to back.
      if (with_hold && sent == items / 3) begin
        hold_requests++;
        burst_left = LONG_HOLD;
      end
      // The sender waits here until every outstanding result has arrived.
      if (with_drain && sent == items / 2) wait_for_results();
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_sample(draw_sample(mode, base));
    end
  endtask

  initial begin : main
    logic [THRESH_W-1:0] settings [PHASES];
    int unsigned         phase;
    settings = '{16'd0, 16'hFFFF, THRESH_RESET, 16'd40, 16'd1, 16'd600, 16'd200, 16'd128};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 3 || phase == 5)
        write_threshold(16'($urandom_range(0, 2000)));
      else
        write_threshold(settings[phase]);
      run_random_phase(PHASE_ITEMS, phase == 2, phase == 4);
    end
    wait_for_results();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending_q.size());
      sb.mismatches += sb.pending_q.size();
    end
    $display("Summary: %0d samples and %0d results checked, %0d presence changes, %0d saturated.",
             sb.samples_seen, sb.results_seen, sb.presence_flips, sb.saturations);
    $display("Summary: %0d threshold settings, a long receiver hold-off, a mid-run drain.",
             thresholds_used);
    if (sb.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/wvpd_pkg.sv
rtl/wvpd_ram.sv
rtl/windowed_variance_presence_detector_top.sv
verif/windowed_variance_presence_detector_top_tb.sv
